FILE: rtl/bss_pkg.sv
// Package for the bounded substring search block.
// Holds widths, status codes, register indexes, shared types and the case fold.
// No dependencies.
package bss_pkg;

  localparam int MAX_NEEDLE = 16;
  localparam int BYTE_W     = 8;
  localparam int NIDX_W     = $clog2(MAX_NEEDLE);
  localparam int COUNT_W    = 32;
  localparam int LIMIT_W    = 32;
  localparam int LEN_W      = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_FOUND  = 2'd1,
    ST_MISS   = 2'd2,
    ST_DONE   = 2'd3
  } status_t;

  // A row of bytes, byte 0 in the lowest bits.
  typedef logic [MAX_NEEDLE-1:0][BYTE_W-1:0] byte_vec_t;

  // Needle settings handed to the window comparator.
  typedef struct packed {
    byte_vec_t        needle;
    logic [LEN_W-1:0] len;
    logic             fold;
  } match_cfg_t;

  // Map ASCII lower case letters to upper case when folding is on.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic fold);
    logic [BYTE_W-1:0] res;
    res = b;
    if (fold && (b >= 8'h61) && (b <= 8'h7a)) begin
      res = b - 8'h20;
    end
    return res;
  endfunction

endpackage

FILE: rtl/bounded_substring_search_top.sv
// Top level of the bounded substring search block.
// Depends on bss_pkg and bss_window_match.
//
// Haystack bytes stream in one word per cycle when not stalled; every word yields
// exactly one result word. A word passes an input register, is compared against the
// needle in parallel combinational logic, lands in an output register; window, byte
// count and done flag update with each word, so the block sustains one word per clock
// unless out_tready stalls it. A word with the start flag set begins a new haystack.
// The status is searching, found (with the start index), ended without match, or
// already concluded. The user must write configuration while idle; not enforced.
module bounded_substring_search_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [bss_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bss_pkg::CFG_W-1:0]     cfg_wdata,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] text_byte
  input  logic                          in_tuser,   // [0] string_start
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [31:0] match_start
  output logic [1:0]                    out_tuser   // [1:0] status
);

  // Configuration registers.
  logic [bss_pkg::CFG_W-1:0]   needle_lo_r;
  logic [bss_pkg::CFG_W-1:0]   needle_hi_r;
  logic [bss_pkg::LEN_W-1:0]   needle_len_r;
  logic [bss_pkg::LIMIT_W-1:0] limit_r;
  logic                        fold_r;

  // Input stage.
  logic                        s1_valid_r;
  logic [bss_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                        s1_start_r;

  // Search state.
  bss_pkg::byte_vec_t          win_r;
  logic [bss_pkg::COUNT_W-1:0] count_r;
  logic                        concluded_r;

  // Output stage.
  logic                        out_valid_r;
  bss_pkg::status_t            out_status_r;
  logic [bss_pkg::COUNT_W-1:0] out_start_r;

  logic                        advance;
  logic                        s1_fire;
  bss_pkg::byte_vec_t          base_win;
  bss_pkg::byte_vec_t          shift_win;
  logic [bss_pkg::COUNT_W-1:0] base_count;
  logic                        base_concluded;
  logic [bss_pkg::COUNT_W:0]   seen;
  logic                        hit;
  bss_pkg::match_cfg_t         mcfg;

  bss_pkg::byte_vec_t          win_nxt;
  logic [bss_pkg::COUNT_W-1:0] count_nxt;
  logic                        concluded_nxt;
  bss_pkg::status_t            status_nxt;
  logic [bss_pkg::COUNT_W-1:0] start_nxt;

  // The pipeline moves whenever the output register is empty or being taken.
  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_start_r;
  assign out_tuser  = out_status_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
      limit_r      <= '0;
      fold_r       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        bss_pkg::CFG_NEEDLE_LO:  needle_lo_r  <= cfg_wdata;
        bss_pkg::CFG_NEEDLE_HI:  needle_hi_r  <= cfg_wdata;
        bss_pkg::CFG_NEEDLE_LEN: needle_len_r <= cfg_wdata[bss_pkg::LEN_W-1:0];
        bss_pkg::CFG_LIMIT:      limit_r      <= cfg_wdata[bss_pkg::LIMIT_W-1:0];
        bss_pkg::CFG_FOLD:       fold_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign mcfg.needle = {needle_hi_r, needle_lo_r};
  assign mcfg.len    = needle_len_r;
  assign mcfg.fold   = fold_r;

  // A start flag clears the window and count before this byte is applied.
  assign base_win       = s1_start_r ? '0 : win_r;
  assign base_count     = s1_start_r ? '0 : count_r;
  assign base_concluded = s1_start_r ? 1'b0 : concluded_r;
  assign seen           = {1'b0, base_count} + 33'd1;
  assign shift_win      = {base_win[bss_pkg::MAX_NEEDLE-2:0], s1_byte_r};

  bss_window_match u_match (
    .window (shift_win),
    .cfg    (mcfg),
    .seen   (seen),
    .hit    (hit)
  );

  // Next search state and result for the word in the input stage.
  always_comb begin
    win_nxt       = base_win;
    count_nxt     = base_count;
    concluded_nxt = base_concluded;
    status_nxt    = bss_pkg::ST_SEARCH;
    start_nxt     = '0;
    if (base_concluded) begin
      status_nxt = bss_pkg::ST_DONE;
    end else begin
      if (base_count != '1) begin
        count_nxt = base_count + 32'd1;
      end
      if (s1_byte_r == '0) begin
        concluded_nxt = 1'b1;
        status_nxt    = bss_pkg::ST_MISS;
      end else begin
        win_nxt = shift_win;
        if ((seen <= {1'b0, limit_r}) && hit) begin
          concluded_nxt = 1'b1;
          status_nxt    = bss_pkg::ST_FOUND;
          start_nxt     = bss_pkg::COUNT_W'(seen - (bss_pkg::COUNT_W + 1)'(needle_len_r));
        end else if (seen >= {1'b0, limit_r}) begin
          concluded_nxt = 1'b1;
          status_nxt    = bss_pkg::ST_MISS;
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Search state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      count_r     <= '0;
      concluded_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        win_r       <= win_nxt;
        count_r     <= count_nxt;
        concluded_r <= concluded_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_fire) begin
      out_status_r <= status_nxt;
      out_start_r  <= start_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A found or missed result leaves the search concluded.
  a_end_concludes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (status_nxt == bss_pkg::ST_FOUND || status_nxt == bss_pkg::ST_MISS))
    |=> concluded_r)
    else $error("search not concluded after final result");

  // A concluded search without a start flag answers already concluded.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && concluded_r && !s1_start_r) |-> (status_nxt == bss_pkg::ST_DONE))
    else $error("concluded search produced a live status");

  // A reported match starts no later than the bytes counted so far.
  a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && status_nxt == bss_pkg::ST_FOUND) |=> (out_start_r < count_r))
    else $error("match start beyond byte count");
`endif

endmodule

FILE: rtl/bss_window_match.sv
// Window comparator: checks the newest bytes of the window against the needle.
// Depends on bss_pkg.
module bss_window_match (
  input  bss_pkg::byte_vec_t              window,  // newest byte at index 0
  input  bss_pkg::match_cfg_t             cfg,
  input  logic [bss_pkg::COUNT_W:0]       seen,    // bytes seen including this one
  output logic                            hit
);

  logic [bss_pkg::MAX_NEEDLE-1:0] lane_ok;
  logic                           len_ok;

  // Each window slot j holds needle byte len-1-j; slots past the length pass.
  always_comb begin
    logic [bss_pkg::LEN_W-1:0] idx;
    for (int j = 0; j < bss_pkg::MAX_NEEDLE; j++) begin
      idx = cfg.len - 5'd1 - bss_pkg::LEN_W'(j);
      if (bss_pkg::LEN_W'(j) < cfg.len) begin
        lane_ok[j] = bss_pkg::fold_byte(window[j], cfg.fold) ==
                     bss_pkg::fold_byte(cfg.needle[idx[bss_pkg::NIDX_W-1:0]], cfg.fold);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  // An empty or oversized needle never matches, nor does a short window.
  assign len_ok = (cfg.len != '0) &&
                  (cfg.len <= bss_pkg::LEN_W'(bss_pkg::MAX_NEEDLE)) &&
                  (seen >= (bss_pkg::COUNT_W + 1)'(cfg.len));

  assign hit = len_ok && (&lane_ok);

endmodule
